// ===== src/rect_polar_converter_core_assert.svh =====
// assertion macros used by the converter top level
`ifndef RECT_POLAR_CONVERTER_CORE_ASSERT_SVH
`define RECT_POLAR_CONVERTER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define RPC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define RPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/rpc_pkg.sv =====
// shared constants, types and the arctangent table of the converter
`default_nettype none

package rpc_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int DATA_BITS_DEF     = 16;

   // datapath widths: coordinates carry 40 bits of scale plus growth and sign
   localparam int XY_W     = 43;
   localparam int Z_W      = 34;
   localparam int ATAN_W   = 32;
   localparam int GAIN_W   = 24;
   localparam int GAIN_LAT = 3;

   // inverse cordic gain, 0.60725293500888 in q24
   localparam logic [GAIN_W-1:0] GAIN_Q24 = 24'd10188014;

   localparam logic signed [Z_W-1:0] HALF_TURN    = {{(Z_W-32){1'b0}}, 32'h8000_0000};
   localparam logic signed [Z_W-1:0] QUARTER_TURN = {{(Z_W-32){1'b0}}, 32'h4000_0000};

   typedef struct packed {
      logic valid;
      logic polar;
      logic zero;
   } rpc_meta_type;

   // atan(2^-i) with one turn = 2^32
   function automatic logic [ATAN_W-1:0] atan_turn(input int idx);
      logic [ATAN_W-1:0] val;
      case (idx)
         0:  val = 32'd536870912;
         1:  val = 32'd316933406;
         2:  val = 32'd167458907;
         3:  val = 32'd85004756;
         4:  val = 32'd42667331;
         5:  val = 32'd21354465;
         6:  val = 32'd10679838;
         7:  val = 32'd5340245;
         8:  val = 32'd2670163;
         9:  val = 32'd1335087;
         10: val = 32'd667544;
         11: val = 32'd333772;
         12: val = 32'd166886;
         13: val = 32'd83443;
         14: val = 32'd41722;
         15: val = 32'd20861;
         16: val = 32'd10430;
         17: val = 32'd5215;
         18: val = 32'd2608;
         19: val = 32'd1304;
         20: val = 32'd652;
         21: val = 32'd326;
         22: val = 32'd163;
         23: val = 32'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== src/rpc_channels.sv =====
// valid/ready channel interfaces for request and response items
`default_nettype none

interface rpc_req_if #(parameter int DATA_BITS = rpc_pkg::DATA_BITS_DEF);
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic signed [DATA_BITS-1:0] first_in;
   logic signed [DATA_BITS-1:0] second_in;

   modport source (output valid, action, first_in, second_in, input ready);
   modport sink   (input valid, action, first_in, second_in, output ready);
endinterface

interface rpc_rsp_if #(parameter int DATA_BITS = rpc_pkg::DATA_BITS_DEF);
   logic                      valid;
   logic                      ready;
   logic signed [DATA_BITS:0] first_out;
   logic signed [DATA_BITS-1:0] second_out;

   modport source (output valid, first_out, second_out, input ready);
   modport sink   (input valid, first_out, second_out, output ready);
endinterface

`default_nettype wire

// ===== src/rpc_cell.sv =====
// one cordic micro-rotation cell with its output register
`default_nettype none

module rpc_cell #(
   parameter int STAGE = 0
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             adv,
   input  wire logic signed [rpc_pkg::XY_W-1:0]  x_i,
   input  wire logic signed [rpc_pkg::XY_W-1:0]  y_i,
   input  wire logic signed [rpc_pkg::Z_W-1:0]   z_i,
   input  wire rpc_pkg::rpc_meta_type            meta_i,
   output logic signed [rpc_pkg::XY_W-1:0]       x_o,
   output logic signed [rpc_pkg::XY_W-1:0]       y_o,
   output logic signed [rpc_pkg::Z_W-1:0]        z_o,
   output rpc_pkg::rpc_meta_type                 meta_o
);
   import rpc_pkg::*;

   localparam logic signed [Z_W-1:0] ATAN = {{(Z_W-ATAN_W){1'b0}}, atan_turn(STAGE)};

   logic                   ccw;
   logic signed [XY_W-1:0] xs, ys;
   logic signed [XY_W-1:0] x_in, y_in, x_ff, y_ff;
   logic signed [Z_W-1:0]  z_in, z_ff;
   logic                   valid_ff, polar_ff, zero_ff;

   // vectoring drives y toward zero, rotation drives z toward zero
   always_comb begin
      ccw  = meta_i.polar ? ~z_i[Z_W-1] : y_i[XY_W-1];
      xs   = x_i >>> STAGE;
      ys   = y_i >>> STAGE;
      x_in = ccw ? x_i - ys : x_i + ys;
      y_in = ccw ? y_i + xs : y_i - xs;
      z_in = ccw ? z_i - ATAN : z_i + ATAN;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= meta_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         z_ff     <= z_in;
         polar_ff <= meta_i.polar;
         zero_ff  <= meta_i.zero;
      end
   end

   assign x_o    = x_ff;
   assign y_o    = y_ff;
   assign z_o    = z_ff;
   assign meta_o = '{valid: valid_ff, polar: polar_ff, zero: zero_ff};

endmodule

`default_nettype wire

// ===== src/rpc_prep.sv =====
// input stage: scales the item and folds it into the cordic range
`default_nettype none

module rpc_prep #(
   parameter int DATA_BITS = rpc_pkg::DATA_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            adv,
   input  wire logic                            valid_i,
   input  wire logic                            action,
   input  wire logic signed [DATA_BITS-1:0]     first_in,
   input  wire logic signed [DATA_BITS-1:0]     second_in,
   output logic signed [rpc_pkg::XY_W-1:0]      x_o,
   output logic signed [rpc_pkg::XY_W-1:0]      y_o,
   output logic signed [rpc_pkg::Z_W-1:0]       z_o,
   output rpc_pkg::rpc_meta_type                meta_o
);
   import rpc_pkg::*;

   localparam int GUARD   = 40 - DATA_BITS;
   localparam int ANG_SHL = 32 - DATA_BITS;

   logic signed [XY_W-1:0] a_ext, b_ext, m_ext;
   logic signed [Z_W-1:0]  zb;
   logic signed [XY_W-1:0] x_in, y_in, x_ff, y_ff;
   logic signed [Z_W-1:0]  z_in, z_ff;
   logic                   zero_in;
   logic                   valid_ff, polar_ff, zero_ff;

   always_comb begin
      a_ext   = {{(XY_W-DATA_BITS){first_in[DATA_BITS-1]}}, first_in} <<< GUARD;
      b_ext   = {{(XY_W-DATA_BITS){second_in[DATA_BITS-1]}}, second_in} <<< GUARD;
      zb      = {{(Z_W-DATA_BITS){second_in[DATA_BITS-1]}}, second_in} <<< ANG_SHL;
      m_ext   = first_in[DATA_BITS-1] ? '0 : a_ext;
      zero_in = (first_in == '0) && (second_in == '0);
      if (!action) begin
         // left half plane: reflect through the origin and start at half a turn
         if (first_in[DATA_BITS-1]) begin
            x_in = -a_ext;
            y_in = -b_ext;
            z_in = HALF_TURN;
         end else begin
            x_in = a_ext;
            y_in = b_ext;
            z_in = '0;
         end
      end else begin
         y_in = '0;
         if (zb > QUARTER_TURN) begin
            x_in = -m_ext;
            z_in = zb - HALF_TURN;
         end else if (zb < -QUARTER_TURN) begin
            x_in = -m_ext;
            z_in = zb + HALF_TURN;
         end else begin
            x_in = m_ext;
            z_in = zb;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         z_ff     <= z_in;
         polar_ff <= action;
         zero_ff  <= zero_in;
      end
   end

   assign x_o    = x_ff;
   assign y_o    = y_ff;
   assign z_o    = z_ff;
   assign meta_o = '{valid: valid_ff, polar: polar_ff, zero: zero_ff};

endmodule

`default_nettype wire

// ===== src/rpc_gain.sv =====
// three-stage gain removal: magnitude, split multiply, round and scale down
`default_nettype none

module rpc_gain #(
   parameter int DATA_BITS = rpc_pkg::DATA_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          adv,
   input  wire logic signed [rpc_pkg::XY_W-1:0] value_i,
   output logic signed [DATA_BITS+2:0]        value_o
);
   import rpc_pkg::*;

   localparam int LO_W   = 22;
   localparam int HI_W   = XY_W - LO_W;
   localparam int PROD_W = XY_W + GAIN_W;
   localparam int SH     = 64 - DATA_BITS;
   localparam int M_W    = DATA_BITS + 2;

   localparam logic [PROD_W-1:0] ROUND = {{(PROD_W-1){1'b0}}, 1'b1} << (SH - 1);

   logic                     neg1_ff, neg2_ff, neg3_ff;
   logic [XY_W-1:0]          abs_in, abs_ff;
   logic [LO_W+GAIN_W-1:0]   pp_lo_in, pp_lo_ff;
   logic [HI_W+GAIN_W-1:0]   pp_hi_in, pp_hi_ff;
   logic [PROD_W-1:0]        sum;
   logic [M_W-1:0]           mag_in, mag_ff;
   logic signed [M_W:0]      mag_s;

   always_comb begin
      abs_in   = value_i[XY_W-1] ? XY_W'(-value_i) : XY_W'(value_i);
      pp_lo_in = {{GAIN_W{1'b0}}, abs_ff[LO_W-1:0]} * {{LO_W{1'b0}}, GAIN_Q24};
      pp_hi_in = {{GAIN_W{1'b0}}, abs_ff[XY_W-1:LO_W]} * {{HI_W{1'b0}}, GAIN_Q24};
      sum      = {pp_hi_ff, {LO_W{1'b0}}} + {{(PROD_W-LO_W-GAIN_W){1'b0}}, pp_lo_ff} + ROUND;
      mag_in   = sum[SH +: M_W];
      mag_s    = {1'b0, mag_ff};
      value_o  = neg3_ff ? -mag_s : mag_s;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         neg1_ff  <= value_i[XY_W-1];
         abs_ff   <= abs_in;
         neg2_ff  <= neg1_ff;
         pp_lo_ff <= pp_lo_in;
         pp_hi_ff <= pp_hi_in;
         neg3_ff  <= neg2_ff;
         mag_ff   <= mag_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/rect_polar_converter_core.sv =====
// top level: pipelined cordic rectangular/polar converter with skid output
//
// request items arrive on req_chan (action, first_in, second_in) and each gives
// exactly one response item on rsp_chan (first_out, second_out), in order.
// action 0: (x, y) -> (magnitude, binary angle); action 1: (magnitude, angle)
// -> (x, y) saturated to the signed data range.
// from acceptance to rsp valid an item passes one input fold stage, one cell
// per micro-rotation, three gain-removal stages and the output register.
// throughput is one item per cycle; the chain of cells advances every cycle
// that the skid register is empty.
// when the receiver stalls, the output register holds its item and the next
// finished item lands in the skid register; the chain then freezes and
// req_chan.ready drops until the skid register drains.
// reset (synchronous, active high) clears every valid bit; in-flight items
// are dropped, req_chan.ready stays low while reset is high and the block
// takes items from the first cycle after reset.
`default_nettype none
`include "rect_polar_converter_core_assert.svh"

module rect_polar_converter_core #(
   parameter int CORDIC_STAGES = rpc_pkg::CORDIC_STAGES_DEF,
   parameter int DATA_BITS     = rpc_pkg::DATA_BITS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   rpc_req_if.sink   req_chan,
   rpc_rsp_if.source rsp_chan
);
   import rpc_pkg::*;

   // half-lsb round for the 32-bit turn down to the output angle width
   localparam logic [31:0] ANG_ROUND = (32'd1 << (32 - DATA_BITS)) >> 1;

   localparam logic signed [DATA_BITS+2:0] SMAX = {4'b0000, {(DATA_BITS-1){1'b1}}};
   localparam logic signed [DATA_BITS+2:0] SMIN = {4'b1111, {(DATA_BITS-1){1'b0}}};
   localparam logic signed [DATA_BITS+2:0] UMAX = {3'b000, {DATA_BITS{1'b1}}};

   // chain advance: frozen only while the skid register is occupied
   logic adv;

   logic signed [XY_W-1:0] x_c [CORDIC_STAGES+1];
   logic signed [XY_W-1:0] y_c [CORDIC_STAGES+1];
   logic signed [Z_W-1:0]  z_c [CORDIC_STAGES+1];
   rpc_meta_type           meta_c [CORDIC_STAGES+1];

   rpc_prep #(
      .DATA_BITS(DATA_BITS)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .valid_i   (req_chan.valid),
      .action    (req_chan.action),
      .first_in  (req_chan.first_in),
      .second_in (req_chan.second_in),
      .x_o       (x_c[0]),
      .y_o       (y_c[0]),
      .z_o       (z_c[0]),
      .meta_o    (meta_c[0])
   );

   // one micro-rotation per cell, shift and arctangent fixed by position
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      rpc_cell #(
         .STAGE(i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .x_i    (x_c[i]),
         .y_i    (y_c[i]),
         .z_i    (z_c[i]),
         .meta_i (meta_c[i]),
         .x_o    (x_c[i+1]),
         .y_o    (y_c[i+1]),
         .z_o    (z_c[i+1]),
         .meta_o (meta_c[i+1])
      );
   end

   // gain removal on both coordinates
   logic signed [DATA_BITS+2:0] gx, gy;

   rpc_gain #(
      .DATA_BITS(DATA_BITS)
   ) u_gain_x (
      .clock   (clock),
      .adv     (adv),
      .value_i (x_c[CORDIC_STAGES]),
      .value_o (gx)
   );

   rpc_gain #(
      .DATA_BITS(DATA_BITS)
   ) u_gain_y (
      .clock   (clock),
      .adv     (adv),
      .value_i (y_c[CORDIC_STAGES]),
      .value_o (gy)
   );

   // side lane that keeps item flags and the rounded angle beside the gain stages
   logic [31:0]          ang_sum;
   logic [DATA_BITS-1:0] ang_in;
   logic [GAIN_LAT-1:0]  lane_valid_ff;
   logic [GAIN_LAT-1:0]  lane_polar_ff;
   logic [GAIN_LAT-1:0]  lane_zero_ff;
   logic [DATA_BITS-1:0] lane_ang_ff [GAIN_LAT];

   always_comb begin
      ang_sum = z_c[CORDIC_STAGES][31:0] + ANG_ROUND;
      ang_in  = ang_sum[31 -: DATA_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff <= '0;
      end else if (adv) begin
         lane_valid_ff <= {lane_valid_ff[GAIN_LAT-2:0], meta_c[CORDIC_STAGES].valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lane_polar_ff  <= {lane_polar_ff[GAIN_LAT-2:0], meta_c[CORDIC_STAGES].polar};
         lane_zero_ff   <= {lane_zero_ff[GAIN_LAT-2:0], meta_c[CORDIC_STAGES].zero};
         lane_ang_ff[0] <= ang_in;
         for (int k = 1; k < GAIN_LAT; k++) begin
            lane_ang_ff[k] <= lane_ang_ff[k-1];
         end
      end
   end

   // final saturation and selection per action
   logic                        res_valid;
   logic signed [DATA_BITS:0]   res_first;
   logic signed [DATA_BITS-1:0] res_second;
   logic signed [DATA_BITS-1:0] x_sat, y_sat;
   logic        [DATA_BITS-1:0] mag_sat;

   always_comb begin
      res_valid = lane_valid_ff[GAIN_LAT-1];
      if (gx > SMAX) begin
         x_sat = SMAX[DATA_BITS-1:0];
      end else if (gx < SMIN) begin
         x_sat = SMIN[DATA_BITS-1:0];
      end else begin
         x_sat = gx[DATA_BITS-1:0];
      end
      if (gy > SMAX) begin
         y_sat = SMAX[DATA_BITS-1:0];
      end else if (gy < SMIN) begin
         y_sat = SMIN[DATA_BITS-1:0];
      end else begin
         y_sat = gy[DATA_BITS-1:0];
      end
      if (gx > UMAX) begin
         mag_sat = UMAX[DATA_BITS-1:0];
      end else if (gx[DATA_BITS+2]) begin
         mag_sat = '0;
      end else begin
         mag_sat = gx[DATA_BITS-1:0];
      end
      if (lane_polar_ff[GAIN_LAT-1]) begin
         res_first  = {x_sat[DATA_BITS-1], x_sat};
         res_second = y_sat;
      end else if (lane_zero_ff[GAIN_LAT-1]) begin
         // zero vector: magnitude and angle both zero
         res_first  = '0;
         res_second = '0;
      end else begin
         res_first  = {1'b0, mag_sat};
         res_second = lane_ang_ff[GAIN_LAT-1];
      end
   end

   // output register plus one skid register
   logic                        out_valid_in, out_valid_ff;
   logic                        skid_valid_in, skid_valid_ff;
   logic                        out_load, skid_load;
   logic signed [DATA_BITS:0]   out_first_in, out_first_ff, skid_first_ff;
   logic signed [DATA_BITS-1:0] out_second_in, out_second_ff, skid_second_ff;

   assign adv = ~skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_load      = 1'b0;
      skid_load     = 1'b0;
      out_first_in  = res_first;
      out_second_in = res_second;
      if (skid_valid_ff) begin
         if (rsp_chan.ready) begin
            out_load      = 1'b1;
            skid_valid_in = 1'b0;
            out_first_in  = skid_first_ff;
            out_second_in = skid_second_ff;
         end
      end else if (!out_valid_ff || rsp_chan.ready) begin
         out_load     = 1'b1;
         out_valid_in = res_valid;
      end else if (res_valid) begin
         skid_load     = 1'b1;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_first_ff  <= out_first_in;
         out_second_ff <= out_second_in;
      end
      if (skid_load) begin
         skid_first_ff  <= res_first;
         skid_second_ff <= res_second;
      end
   end

   // no item is taken while reset is high
   assign req_chan.ready      = adv && !reset;
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.first_out  = out_first_ff;
   assign rsp_chan.second_out = out_second_ff;

   // skid register only ever holds an item behind a waiting output item
   `RPC_ASSERT_IMPL(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff, "skid item without output item")
   // a finished item meeting a stalled output goes to the skid register
   `RPC_ASSERT_NEXT(a_skid_fill, clock, reset, out_valid_ff && !rsp_chan.ready && !skid_valid_ff && lane_valid_ff[GAIN_LAT-1], skid_valid_ff, "finished item not caught by skid register")
   // a taken output item is replaced by the skid item
   `RPC_ASSERT_NEXT(a_skid_drain, clock, reset, out_valid_ff && skid_valid_ff && rsp_chan.ready, out_valid_ff && !skid_valid_ff, "skid register did not drain")
   // the gain lane holds still while the chain is frozen
   `RPC_ASSERT_NEXT(a_lane_frozen, clock, reset, skid_valid_ff, $stable(lane_valid_ff), "gain lane moved while frozen")

endmodule

`default_nettype wire
